FILE: design/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Constants, codes and types shared by the buddy allocator files.
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam int MAX_ORDER       = 16;
	localparam int MIN_BLOCK_ORDER = 6;
	localparam int HEADER_BYTES    = 24;

	localparam int ADDR_BITS  = 16;
	localparam int SLOT_BITS  = ADDR_BITS - MIN_BLOCK_ORDER;
	localparam int SLOT_COUNT = 1 << SLOT_BITS;
	localparam int LINK_BITS  = SLOT_BITS + 1;
	localparam int ORDER_TOP  = (MAX_ORDER < ADDR_BITS) ? MAX_ORDER : ADDR_BITS;
	localparam int ORDER_HI   = (ORDER_TOP < MIN_BLOCK_ORDER) ? MIN_BLOCK_ORDER : ORDER_TOP;
	localparam int ORDER_W    = 5;
	localparam int HEAD_COUNT = ADDR_BITS + 1;
	localparam int SIZE_W     = ADDR_BITS + 1;
	localparam int CFG_W      = 5;
	localparam int POOL_RESET = 16;

	localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(SLOT_COUNT);

	typedef enum logic [1:0] {
		TAG_UNUSED   = 2'd0,
		TAG_FREE     = 2'd1,
		TAG_RESERVED = 2'd2
	} tag_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_MEM  = 2'd1,
		ST_ZERO    = 2'd2
	} status_t;

	typedef struct packed {
		tag_t               tag;
		logic [ORDER_W-1:0] order;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	function automatic logic [ORDER_W-1:0] eff_order(input logic [CFG_W-1:0] po);
		logic [ORDER_W-1:0] r;
		r = ORDER_W'(po);
		if (r < ORDER_W'(MIN_BLOCK_ORDER)) r = ORDER_W'(MIN_BLOCK_ORDER);
		if (r > ORDER_W'(ORDER_HI)) r = ORDER_W'(ORDER_HI);
		return r;
	endfunction

endpackage

FILE: design/buddy_memory_allocator.sv
// ----------------------------------------------------------------------------
// buddy_memory_allocator
// Binary buddy allocator. Block tags, orders and free-list links live in
// synchronous RAMs; a sequencer walks the lists, splits and merges blocks.
//
//   Channel  Handshake          Payload
//   in       in_valid/in_stall  req_type, req_size, free_offset
//   out      out_valid/out_stall status, user_offset
//   cfg      cfg_valid/cfg_ready pool_order
//
// An allocate searches the free lists from the needed order upward and then
// splits the found block down; a free merges with the buddy level by level,
// waiting on the registered reads of the tag and link RAMs. After reset and
// after each pool_order write a clearing pass over all 1024 slots rewrites
// the tag RAM; no request is taken meanwhile, nor while a pool_order write is
// pending. A stalled result holds in the output register while the next
// request is already accepted and worked on.
// ----------------------------------------------------------------------------
module buddy_memory_allocator
	import bma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [15:0]          req_size,
	input  logic [15:0]          free_offset,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [15:0]          user_offset,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     pool_order
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_SEARCH, S_A_RDLINK, S_A_UNLINK, S_A_SPLIT,
		S_F_RDMETA, S_F_CHECK, S_F_STEP, S_F_BUDDY, S_F_UNLINK,
		S_F_PUSH1, S_F_PUSH2, S_DONE
	} state_t;

	state_t                 state_q;
	logic [ORDER_W-1:0]     eff_q;
	logic [LINK_BITS-1:0]   head_q [HEAD_COUNT];
	logic [SLOT_BITS-1:0]   clr_q;
	logic [ORDER_W-1:0]     k_q;
	logic [ORDER_W-1:0]     i_q;
	logic [SLOT_BITS-1:0]   s_q;
	logic [SLOT_BITS-1:0]   b_q;
	logic [LINK_BITS-1:0]   h_q;
	status_t                res_st_q;
	logic [15:0]            res_off_q;
	logic                   out_valid_q;
	status_t                out_st_q;
	logic [15:0]            out_off_q;

	logic                   meta_we, meta_re, next_we, next_re, prev_we, prev_re;
	logic [SLOT_BITS-1:0]   meta_wa, meta_ra, next_wa, next_ra, prev_wa, prev_ra;
	meta_t                  meta_wd;
	logic [META_W-1:0]      meta_rd;
	logic [LINK_BITS-1:0]   next_wd, next_rd, prev_wd, prev_rd;
	meta_t                  meta_r;

	logic                   in_acc;
	logic                   cfg_acc;
	logic [SIZE_W-1:0]      tot_m1;
	logic [ORDER_W-1:0]     k_c;
	logic [ADDR_BITS-1:0]   off_c;
	logic                   foff_ok;
	logic [ORDER_W-1:0]     i_dn;
	logic [SLOT_BITS-1:0]   b_split;
	logic [SLOT_BITS-1:0]   b_merge;

	assign meta_r    = meta_t'(meta_rd);
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign user_offset = out_off_q;

	always_comb begin
		tot_m1 = SIZE_W'(req_size) + SIZE_W'(HEADER_BYTES) - SIZE_W'(1);
		k_c = '0;
		for (int j = 0; j < SIZE_W; j++) begin
			if (tot_m1[j]) k_c = ORDER_W'(j + 1);
		end
		if (k_c < ORDER_W'(MIN_BLOCK_ORDER)) k_c = ORDER_W'(MIN_BLOCK_ORDER);
		off_c   = free_offset - ADDR_BITS'(HEADER_BYTES);
		foff_ok = (free_offset >= ADDR_BITS'(HEADER_BYTES))
			&& (off_c[MIN_BLOCK_ORDER-1:0] == '0)
			&& ((off_c >> eff_q) == '0);
		i_dn    = i_q - ORDER_W'(1);
		b_split = s_q + (SLOT_BITS'(1) << (i_dn - ORDER_W'(MIN_BLOCK_ORDER)));
		b_merge = s_q ^ (SLOT_BITS'(1) << (i_q - ORDER_W'(MIN_BLOCK_ORDER)));
	end

	always_comb begin
		meta_we = 1'b0; meta_wa = s_q; meta_wd = '{tag: TAG_UNUSED, order: i_q};
		meta_re = 1'b0; meta_ra = s_q;
		next_we = 1'b0; next_wa = s_q; next_wd = NIL;
		next_re = 1'b0; next_ra = s_q;
		prev_we = 1'b0; prev_wa = s_q; prev_wd = NIL;
		prev_re = 1'b0; prev_ra = b_q;
		unique case (state_q)
			S_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				if (clr_q == '0) begin
					meta_wd = '{tag: TAG_FREE, order: eff_q};
					next_we = 1'b1; next_wa = '0;
					prev_we = 1'b1; prev_wa = '0;
				end else begin
					meta_wd = '{tag: TAG_UNUSED, order: '0};
				end
			end
			S_A_RDLINK: next_re = 1'b1;
			S_A_UNLINK: begin
				if (next_rd != NIL) begin
					prev_we = 1'b1;
					prev_wa = next_rd[SLOT_BITS-1:0];
				end
			end
			S_A_SPLIT: begin
				meta_we = 1'b1;
				if (i_q > k_q) begin
					meta_wa = b_split;
					meta_wd = '{tag: TAG_FREE, order: i_dn};
					next_we = 1'b1; next_wa = b_split;
					prev_we = 1'b1; prev_wa = b_split;
				end else begin
					meta_wd = '{tag: TAG_RESERVED, order: k_q};
				end
			end
			S_F_RDMETA: meta_re = 1'b1;
			S_F_STEP: begin
				meta_re = 1'b1;
				meta_ra = b_merge;
			end
			S_F_BUDDY: begin
				next_re = 1'b1; next_ra = b_q;
				prev_re = 1'b1; prev_ra = b_q;
			end
			S_F_UNLINK: begin
				if (prev_rd != NIL) begin
					next_we = 1'b1;
					next_wa = prev_rd[SLOT_BITS-1:0];
					next_wd = next_rd;
				end
				if (next_rd != NIL) begin
					prev_we = 1'b1;
					prev_wa = next_rd[SLOT_BITS-1:0];
					prev_wd = prev_rd;
				end
				meta_we = 1'b1;
				meta_wa = (b_q < s_q) ? s_q : b_q;
			end
			S_F_PUSH1: begin
				next_we = 1'b1; next_wd = head_q[i_q];
				prev_we = 1'b1;
				meta_we = 1'b1;
				meta_wd = '{tag: TAG_FREE, order: i_q};
			end
			S_F_PUSH2: begin
				if (h_q != NIL) begin
					prev_we = 1'b1;
					prev_wa = h_q[SLOT_BITS-1:0];
					prev_wd = LINK_BITS'(s_q);
				end
			end
			default: ;
		endcase
	end

	bma_ram #(.W(META_W), .DEPTH(SLOT_COUNT)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
		.re(meta_re), .raddr(meta_ra), .rdata(meta_rd)
	);

	bma_ram #(.W(LINK_BITS), .DEPTH(SLOT_COUNT)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.re(next_re), .raddr(next_ra), .rdata(next_rd)
	);

	bma_ram #(.W(LINK_BITS), .DEPTH(SLOT_COUNT)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.re(prev_re), .raddr(prev_ra), .rdata(prev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			eff_q       <= eff_order(CFG_W'(POOL_RESET));
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < HEAD_COUNT; j++) begin
				head_q[j] <= (j == int'(eff_order(CFG_W'(POOL_RESET)))) ? '0 : NIL;
			end
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_acc) begin
				eff_q   <= eff_order(pool_order);
				clr_q   <= '0;
				state_q <= S_CLEAR;
				for (int j = 0; j < HEAD_COUNT; j++) begin
					head_q[j] <= (ORDER_W'(j) == eff_order(pool_order)) ? '0 : NIL;
				end
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + SLOT_BITS'(1);
						if (clr_q == {SLOT_BITS{1'b1}}) state_q <= S_IDLE;
					end
					S_IDLE: begin
						res_st_q  <= ST_OK;
						res_off_q <= '0;
						if (in_acc) begin
							if (req_type) begin
								s_q     <= off_c[ADDR_BITS-1:MIN_BLOCK_ORDER];
								state_q <= foff_ok ? S_F_RDMETA : S_DONE;
							end else if (req_size == '0) begin
								res_st_q <= ST_ZERO;
								state_q  <= S_DONE;
							end else if (k_c > eff_q) begin
								res_st_q <= ST_NO_MEM;
								state_q  <= S_DONE;
							end else begin
								k_q     <= k_c;
								i_q     <= k_c;
								state_q <= S_A_SEARCH;
							end
						end
					end
					S_A_SEARCH: begin
						if (head_q[i_q] != NIL) begin
							s_q     <= head_q[i_q][SLOT_BITS-1:0];
							state_q <= S_A_RDLINK;
						end else if (i_q == eff_q) begin
							res_st_q <= ST_NO_MEM;
							state_q  <= S_DONE;
						end else begin
							i_q <= i_q + ORDER_W'(1);
						end
					end
					S_A_RDLINK: state_q <= S_A_UNLINK;
					S_A_UNLINK: begin
						head_q[i_q] <= next_rd;
						state_q     <= S_A_SPLIT;
					end
					S_A_SPLIT: begin
						if (i_q > k_q) begin
							head_q[i_dn] <= LINK_BITS'(b_split);
							i_q          <= i_dn;
						end else begin
							res_off_q <= (ADDR_BITS'(s_q) << MIN_BLOCK_ORDER)
								+ ADDR_BITS'(HEADER_BYTES);
							state_q   <= S_DONE;
						end
					end
					S_F_RDMETA: state_q <= S_F_CHECK;
					S_F_CHECK: begin
						if (meta_r.tag == TAG_RESERVED) begin
							i_q     <= meta_r.order;
							state_q <= S_F_STEP;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_F_STEP: begin
						b_q     <= b_merge;
						state_q <= (i_q < eff_q) ? S_F_BUDDY : S_F_PUSH1;
					end
					S_F_BUDDY: begin
						if (meta_r.tag == TAG_FREE && meta_r.order == i_q) state_q <= S_F_UNLINK;
						else state_q <= S_F_PUSH1;
					end
					S_F_UNLINK: begin
						if (prev_rd == NIL) head_q[i_q] <= next_rd;
						if (b_q < s_q) s_q <= b_q;
						i_q     <= i_q + ORDER_W'(1);
						state_q <= S_F_STEP;
					end
					S_F_PUSH1: begin
						h_q         <= head_q[i_q];
						head_q[i_q] <= LINK_BITS'(s_q);
						state_q     <= S_F_PUSH2;
					end
					S_F_PUSH2: state_q <= S_DONE;
					S_DONE: begin
						if (!out_valid_q || !out_stall) begin
							out_st_q    <= res_st_q;
							out_off_q   <= res_off_q;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

FILE: design/bma_ram.sv
// ----------------------------------------------------------------------------
// bma_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bma_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buddy allocator. A directed table and several
// random phases of allocate and free requests are driven through the request
// channel. Every result is compared with a software allocator that tracks
// free lists, block tags and orders, across several pool sizes.
// ----------------------------------------------------------------------------
module tb;
	import bma_pkg::*;

	localparam int NSLOT = 1024;
	localparam logic [10:0] NONE = 11'd1024;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [15:0] req_size = '0;
	logic [15:0] free_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [15:0] user_offset;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] pool_order = '0;

	buddy_memory_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .req_size(req_size), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .user_offset(user_offset),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_order(pool_order)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	typedef struct {
		logic [1:0]  st;
		logic [15:0] off;
	} answer_t;

	typedef struct {
		logic        kind;
		logic [15:0] size;
		logic [15:0] foff;
		logic        typed;
		logic [1:0]  st;
		logic [15:0] off;
	} row_t;

	answer_t answers[$];
	logic [15:0] live[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	int unsigned idle_pct = 24;

	logic [4:0]  pool_eff;
	logic [10:0] heads[17];
	tag_t        tags[NSLOT];
	logic [4:0]  ords[NSLOT];
	logic [10:0] nxt[NSLOT];
	logic [10:0] prv[NSLOT];

	function automatic void push_free(int o, int s);
		nxt[s] = heads[o];
		prv[s] = NONE;
		if (heads[o] != NONE) prv[heads[o]] = 11'(s);
		heads[o] = 11'(s);
	endfunction

	function automatic void unlink_free(int o, int s);
		logic [10:0] n, p;
		n = nxt[s];
		p = prv[s];
		if (p != NONE) nxt[p] = n;
		else heads[o] = n;
		if (n != NONE) prv[n] = p;
	endfunction

	function automatic void pool_reinit(logic [4:0] po);
		int lo;
		lo = MIN_BLOCK_ORDER;
		pool_eff = po < lo ? 5'(lo) : (po > ORDER_HI ? 5'(ORDER_HI) : po);
		for (int i = 0; i < 17; i++) heads[i] = NONE;
		for (int i = 0; i < NSLOT; i++) begin
			tags[i] = TAG_UNUSED;
			ords[i] = '0;
		end
		tags[0] = TAG_FREE;
		ords[0] = pool_eff;
		push_free(pool_eff, 0);
	endfunction

	function automatic answer_t allocate_block(logic [15:0] size);
		answer_t a;
		int total, k, i, s, b;
		a.st = ST_OK;
		a.off = '0;
		if (size == 0) begin
			a.st = ST_ZERO;
			return a;
		end
		total = size + HEADER_BYTES;
		k = 0;
		while (k < 20 && (1 << k) < total) k++;
		if (k < MIN_BLOCK_ORDER) k = MIN_BLOCK_ORDER;
		if (k > pool_eff) begin
			a.st = ST_NO_MEM;
			return a;
		end
		i = k;
		while (i <= pool_eff && heads[i] == NONE) i++;
		if (i > pool_eff) begin
			a.st = ST_NO_MEM;
			return a;
		end
		s = heads[i];
		unlink_free(i, s);
		while (i > k) begin
			i--;
			b = s + (1 << (i - MIN_BLOCK_ORDER));
			tags[b] = TAG_FREE;
			ords[b] = 5'(i);
			ords[s] = 5'(i);
			push_free(i, b);
		end
		tags[s] = TAG_RESERVED;
		ords[s] = 5'(k);
		a.off = 16'((s << MIN_BLOCK_ORDER) + HEADER_BYTES);
		return a;
	endfunction

	function automatic void release_block(logic [15:0] uoff);
		int off, s, o, b;
		if (uoff < HEADER_BYTES) return;
		off = uoff - HEADER_BYTES;
		if (off % (1 << MIN_BLOCK_ORDER) != 0) return;
		if (off >= (1 << pool_eff)) return;
		s = off >> MIN_BLOCK_ORDER;
		if (tags[s] != TAG_RESERVED) return;
		tags[s] = TAG_FREE;
		o = ords[s];
		while (o < pool_eff) begin
			b = s ^ (1 << (o - MIN_BLOCK_ORDER));
			if (b >= NSLOT || tags[b] != TAG_FREE || ords[b] != o) break;
			unlink_free(o, b);
			if (b < s) begin
				tags[s] = TAG_UNUSED;
				s = b;
			end else begin
				tags[b] = TAG_UNUSED;
			end
			o++;
			ords[s] = 5'(o);
		end
		push_free(o, s);
	endfunction

	function automatic answer_t predict_request(logic kind, logic [15:0] size, logic [15:0] foff);
		answer_t a;
		a.st = ST_OK;
		a.off = '0;
		if (kind == REQ_ALLOC) a = allocate_block(size);
		else release_block(foff);
		return a;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (answers.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = answers.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (user_offset !== e.off) begin
					$error("user_offset expected %0h actual %0h", e.off, user_offset);
					errors++;
				end
				if (e.st == ST_OK && e.off != 0) live.push_back(e.off);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= (!quiet && $urandom_range(99) < idle_pct);
	end

	task automatic send_request(logic kind, logic [15:0] size, logic [15:0] foff,
			logic typed, logic [1:0] st, logic [15:0] off);
		answer_t a;
		while (!quiet && $urandom_range(99) < idle_pct) @(negedge clk);
		req_type <= kind;
		req_size <= size;
		free_offset <= foff;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		a = predict_request(kind, size, foff);
		if (typed && (a.st != st || a.off != off)) begin
			$error("table row disagrees: status %0d offset %0h", a.st, a.off);
			errors++;
		end
		answers.push_back(a);
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (answers.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_pool(logic [4:0] po);
		drain_results();
		pool_order <= po;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pool_reinit(po);
		live.delete();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		int idx;
		logic [15:0] sz;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					sz = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 300));
					send_request(REQ_ALLOC, sz, 16'($urandom), 0, 0, 0);
				end
				4, 5, 6, 7: begin
					if (live.size() != 0) begin
						idx = $urandom_range(live.size() - 1);
						sz = live[idx];
						live.delete(idx);
					end else begin
						sz = 16'($urandom);
					end
					send_request(REQ_FREE, 16'($urandom), sz, 0, 0, 0);
				end
				8: send_request(REQ_FREE, 16'($urandom), 16'($urandom), 0, 0, 0);
				default: send_request(REQ_ALLOC, 16'($urandom_range(0, 2)), 16'($urandom),
						0, 0, 0);
			endcase
		end
	endtask

	row_t dir[$];

	initial begin
		pool_reinit(5'(POOL_RESET));
		dir.push_back('{REQ_ALLOC, 16'd0, 16'd0, 1, ST_ZERO, 16'd0});
		dir.push_back('{REQ_ALLOC, 16'hFFFF, 16'hFFFF, 1, ST_NO_MEM, 16'd0});
		dir.push_back('{REQ_ALLOC, 16'd1, 16'd0, 1, ST_OK, 16'd24});
		dir.push_back('{REQ_ALLOC, 16'd40, 16'd0, 1, ST_OK, 16'd88});
		dir.push_back('{REQ_ALLOC, 16'd41, 16'd0, 0, 0, 0});
		dir.push_back('{REQ_FREE, 16'hFFFF, 16'd23, 0, 0, 0});
		dir.push_back('{REQ_FREE, 16'd0, 16'd25, 0, 0, 0});
		dir.push_back('{REQ_FREE, 16'd0, 16'hFFFF, 0, 0, 0});
		dir.push_back('{REQ_FREE, 16'd0, 16'd24, 1, ST_OK, 16'd0});
		dir.push_back('{REQ_FREE, 16'd0, 16'd24, 1, ST_OK, 16'd0});
		dir.push_back('{REQ_FREE, 16'd0, 16'd88, 0, 0, 0});
		dir.push_back('{REQ_FREE, 16'd0, 16'd152, 0, 0, 0});
		dir.push_back('{REQ_ALLOC, 16'd65512, 16'd0, 1, ST_OK, 16'd24});
		dir.push_back('{REQ_ALLOC, 16'd1, 16'd0, 1, ST_NO_MEM, 16'd0});
		dir.push_back('{REQ_FREE, 16'd0, 16'd24, 0, 0, 0});
		dir.push_back('{REQ_ALLOC, 16'd65513, 16'd0, 1, ST_NO_MEM, 16'd0});
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir[i])
			send_request(dir[i].kind, dir[i].size, dir[i].foff,
					dir[i].typed, dir[i].st, dir[i].off);
		write_pool(5'd6);
		send_request(REQ_ALLOC, 16'd40, 16'd0, 1, ST_OK, 16'd24);
		send_request(REQ_ALLOC, 16'd1, 16'd0, 1, ST_NO_MEM, 16'd0);
		send_request(REQ_FREE, 16'd0, 16'd24, 0, 0, 0);
		random_phase(60);
		write_pool(5'd31);
		random_phase(200);
		drain_results();
		quiet = 1'b1;
		random_phase(100);
		quiet = 1'b0;
		write_pool(5'd0);
		random_phase(60);
		write_pool(5'd9);
		random_phase(200);
		write_pool(5'd16);
		random_phase(200);
		drain_results();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: buddy_memory_allocator.f
design/bma_pkg.sv
design/bma_ram.sv
design/buddy_memory_allocator.sv
bench/tb.sv
